>>> rtl/multilevel_vlc_table_decode_defines.svh
// Assertion macros shared by the decoder RTL
`ifndef MULTILEVEL_VLC_TABLE_DECODE_DEFINES_SVH
`define MULTILEVEL_VLC_TABLE_DECODE_DEFINES_SVH

`ifndef SYNTHESIS
// property holds on every edge outside reset
`define MVLC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// condition never occurs outside reset
`define MVLC_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define MVLC_ASSERT(lbl, clk, rst, prop, msg)
`define MVLC_ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif

`endif

>>> rtl/mvlc_pkg.sv
package mvlc_pkg;

  // table geometry
  localparam int TABLE_ENTRIES = 4096;
  localparam int ADDR_W        = $clog2(TABLE_ENTRIES);
  localparam int SYM_W         = 16;
  localparam int LEN_W         = 7;
  localparam int ENTRY_W       = SYM_W + LEN_W;

  // stream window
  localparam int WIN_W   = 32;
  localparam int PEEK_W  = 2 * WIN_W;
  localparam int SHIFT_W = $clog2(WIN_W);
  localparam int NB_W    = LEN_W;            // holds 0..64 link widths

  // level walk
  localparam int LEVEL_LIMIT = 4;
  localparam int LVL_W       = 3;
  localparam int ROOT_W      = 4;
  localparam int POS_W       = 8;            // root + three 64-bit links fit
  localparam int TOT_W       = POS_W + 1;
  localparam int IDX_W       = SYM_W + 2;    // signed base + peeked bits
  localparam int USED_W      = 6;
  localparam int USED_CAP    = 32;

  // command queue
  localparam int QUEUE_DEPTH = 2;            // power of two, pointers wrap
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROOT_BITS  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEVELS = 1'b1;
  localparam int CFG_DATA_W = 4;

  typedef enum logic {
    CMD_WRITE,
    CMD_DECODE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                kind;
    logic [ADDR_W-1:0]        index;
    logic signed [SYM_W-1:0]  sym;
    logic signed [LEN_W-1:0]  len;
    logic [WIN_W-1:0]         window;
  } cmd_t;

  typedef struct packed {
    logic [ROOT_W-1:0] root_bits;
    logic [LVL_W-1:0]  max_levels;
  } cfg_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ADDR,
    BK_READ
  } back_state_t;

endpackage

>>> rtl/mvlc_ram.sv
module mvlc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> rtl/mvlc_front.sv
`include "multilevel_vlc_table_decode_defines.svh"

module mvlc_front import mvlc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic                    mode,
  input  logic [ADDR_W-1:0]       entry_index,
  input  logic signed [SYM_W-1:0] entry_symbol,
  input  logic signed [LEN_W-1:0] entry_length,
  input  logic [WIN_W-1:0]        window_bits,
  output logic                    q_valid,
  output cmd_t                    q_head,
  input  logic                    pop
);

  cmd_t              q_mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  cmd_t              cmd_in;

  // classify the incoming command
  always_comb begin
    cmd_in.kind   = mode ? CMD_DECODE : CMD_WRITE;
    cmd_in.index  = entry_index;
    cmd_in.sym    = entry_symbol;
    cmd_in.len    = entry_length;
    cmd_in.window = window_bits;
  end

  assign busy    = (count == QCNT_W'(QUEUE_DEPTH));
  assign push    = start && !busy;
  assign q_valid = (count != '0);
  assign q_head  = q_mem[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= cmd_in;
    end
  end

  // queue pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `MVLC_ASSERT_NEVER(a_count_bound, clk, rst, count > QCNT_W'(QUEUE_DEPTH), "queue overfilled")
  `MVLC_ASSERT(a_push_fills, clk, rst, !$past(rst) && $past(push) && !$past(pop) |-> count == $past(count) + 1'b1, "transfer lost in queue")

endmodule

>>> rtl/mvlc_back.sv
`include "multilevel_vlc_table_decode_defines.svh"

module mvlc_back import mvlc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     q_valid,
  input  cmd_t                     q_head,
  output logic                     pop,
  input  cfg_t                     cfg,
  output logic                     done,
  output logic signed [SYM_W-1:0]  symbol,
  output logic [USED_W-1:0]        bits_used,
  output logic                     invalid
);

  back_state_t state, state_next;

  // walk registers
  logic [WIN_W-1:0]        window;
  logic [POS_W-1:0]        pos;
  logic [NB_W-1:0]         nb;
  logic signed [SYM_W-1:0] base;
  logic [LVL_W-1:0]        lvl;
  logic [LVL_W-1:0]        lvl_limit;
  logic                    oob;

  // table port
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_addr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;

  // index datapath
  logic [WIN_W-1:0]        win_shift;
  logic [PEEK_W-1:0]       peek_full;
  logic                    peek_big;
  logic signed [IDX_W-1:0] idx_sum;
  logic                    idx_oob;

  // entry evaluation
  logic signed [SYM_W-1:0] ent_sym;
  logic signed [LEN_W-1:0] ent_len;
  logic                    go_deeper;
  logic                    len_pos;
  logic [TOT_W-1:0]        total;
  logic                    bad;
  logic [USED_W-1:0]       used;
  logic [LVL_W-1:0]        limit_cfg;

  mvlc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // level limit clamped to 1..LEVEL_LIMIT
  always_comb begin
    if (cfg.max_levels == '0) begin
      limit_cfg = LVL_W'(1);
    end else if (cfg.max_levels > LVL_W'(LEVEL_LIMIT)) begin
      limit_cfg = LVL_W'(LEVEL_LIMIT);
    end else begin
      limit_cfg = cfg.max_levels;
    end
  end

  // nb window bits at pos, zero past the window, then add the base
  always_comb begin
    win_shift = (pos >= POS_W'(WIN_W)) ? '0 : (window << pos[SHIFT_W-1:0]);
    peek_full = {win_shift, {WIN_W{1'b0}}} >> (NB_W'(PEEK_W) - nb);
    peek_big  = |peek_full[PEEK_W-1:SYM_W];
    idx_sum   = $signed({{(IDX_W-SYM_W){1'b0}}, peek_full[SYM_W-1:0]})
              + $signed({{(IDX_W-SYM_W){base[SYM_W-1]}}, base});
    idx_oob   = peek_big || idx_sum[IDX_W-1]
              || (idx_sum[IDX_W-2:0] >= (IDX_W-1)'(TABLE_ENTRIES));
  end

  // entry just read; out-of-table lookups read as an empty entry
  always_comb begin
    ent_sym   = oob ? '0 : ram_rdata[ENTRY_W-1:LEN_W];
    ent_len   = oob ? '0 : ram_rdata[LEN_W-1:0];
    go_deeper = (lvl < lvl_limit) && ent_len[LEN_W-1];
    len_pos   = !ent_len[LEN_W-1] && (ent_len != '0);
    total     = len_pos ? (TOT_W'(pos) + TOT_W'(ent_len[LEN_W-2:0])) : TOT_W'(pos);
    bad       = !len_pos || (total > TOT_W'(WIN_W));
    used      = (total > TOT_W'(USED_CAP)) ? USED_W'(USED_CAP) : total[USED_W-1:0];
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (q_valid && q_head.kind == CMD_DECODE) begin
          state_next = BK_ADDR;
        end
      end
      BK_ADDR: state_next = BK_READ;
      BK_READ: state_next = go_deeper ? BK_ADDR : BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  // queue pop and table port control
  always_comb begin
    pop       = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = idx_sum[ADDR_W-1:0];
    ram_wdata = {q_head.sym, q_head.len};
    case (state)
      BK_IDLE: begin
        pop = q_valid;
        if (q_valid && q_head.kind == CMD_WRITE) begin
          ram_we   = 1'b1;
          ram_addr = q_head.index;
        end
      end
      BK_ADDR: ram_addr = idx_sum[ADDR_W-1:0];
      BK_READ: ram_addr = idx_sum[ADDR_W-1:0];
      default: ram_addr = idx_sum[ADDR_W-1:0];
    endcase
  end

  // walk registers and result
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      done      <= 1'b0;
      lvl       <= '0;
      lvl_limit <= '0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      case (state)
        BK_IDLE: begin
          if (q_valid && q_head.kind == CMD_DECODE) begin
            window    <= q_head.window;
            pos       <= '0;
            nb        <= NB_W'(cfg.root_bits);
            base      <= '0;
            lvl       <= LVL_W'(1);
            lvl_limit <= limit_cfg;
          end
        end
        BK_ADDR: oob <= idx_oob;
        BK_READ: begin
          if (go_deeper) begin
            pos  <= pos + POS_W'(nb);
            nb   <= NB_W'(-ent_len);
            base <= ent_sym;
            lvl  <= lvl + 1'b1;
          end else begin
            done      <= 1'b1;
            symbol    <= ent_sym;
            bits_used <= used;
            invalid   <= bad;
          end
        end
        default: ;
      endcase
    end
  end

  `MVLC_ASSERT(a_done_after_read, clk, rst, done |-> $past(state) == BK_READ, "result without table read")
  `MVLC_ASSERT(a_level_bound, clk, rst, state != BK_IDLE |-> lvl <= lvl_limit, "walk past level limit")
  `MVLC_ASSERT(a_valid_nonzero, clk, rst, done && !invalid |-> bits_used != '0, "valid symbol consumed no bits")

endmodule

>>> rtl/multilevel_vlc_table_decode.sv
// Table write: one queue slot and one write through the table port.
// Decode walking L levels (1..4): an address and a read state per level; the result strobe is
// registered in the last read; one walk at a time on the single-port registered-read RAM.
// A two-entry command queue accepts new commands while a decode walks; results never stall.
// Synchronous reset clears queue, walker, result strobe and config (root 8, levels 4);
// table contents are kept and hold nothing defined until written.
module multilevel_vlc_table_decode import mvlc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic                     mode,
  input  logic [ADDR_W-1:0]        entry_index,
  input  logic signed [SYM_W-1:0]  entry_symbol,
  input  logic signed [LEN_W-1:0]  entry_length,
  input  logic [WIN_W-1:0]         window_bits,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data,
  output logic                     done,
  output logic signed [SYM_W-1:0]  symbol,
  output logic [USED_W-1:0]        bits_used,
  output logic                     invalid
);

  cfg_t cfg;
  logic q_valid;
  cmd_t q_head;
  logic pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.root_bits  <= ROOT_W'(8);
      cfg.max_levels <= LVL_W'(4);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ROOT_BITS:  cfg.root_bits  <= cfg_data[ROOT_W-1:0];
        CFG_MAX_LEVELS: cfg.max_levels <= cfg_data[LVL_W-1:0];
        default: ;
      endcase
    end
  end

  mvlc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .mode         (mode),
    .entry_index  (entry_index),
    .entry_symbol (entry_symbol),
    .entry_length (entry_length),
    .window_bits  (window_bits),
    .q_valid      (q_valid),
    .q_head       (q_head),
    .pop          (pop)
  );

  mvlc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .pop       (pop),
    .cfg       (cfg),
    .done      (done),
    .symbol    (symbol),
    .bits_used (bits_used),
    .invalid   (invalid)
  );

endmodule
